// ===== rtl/core/hgf_pkg.sv =====
// Shared constants, types and table function for the haversine geofence check.
`timescale 1ns / 1ps

package hgf_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 30;
    localparam int GUARD_BITS          = 10;

    localparam int LAT_W      = 31;
    localparam int LON_W      = 32;
    localparam int DIST_W     = 25;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int TURN_W     = 34;
    localparam int TWO_RADII_W = 24;

    typedef enum logic [STATUS_W-1:0] {
        ST_NO_FIX  = 2'd0,
        ST_INSIDE  = 2'd1,
        ST_OUTSIDE = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_LAT = 2'd0,
        CFG_CENTER_LON = 2'd1,
        CFG_RADIUS     = 2'd2
    } t_cfg_index;

    // Half angles in 5e-8 degree units
    localparam logic signed [TURN_W-1:0] FULL_TURN    = 34'sd7200000000;
    localparam logic signed [TURN_W-1:0] HALF_TURN    = 34'sd3600000000;
    localparam logic        [31:0]       HALF_TURN_U  = 32'd3600000000;
    localparam logic        [31:0]       QUARTER_TURN = 32'd1800000000;

    localparam logic [31:0] RAD_SCALE = 32'd4024455254;
    localparam logic [TWO_RADII_W-1:0] TWO_RADII_M = 24'd12742000;
    localparam logic [63:0] QUARTER_PI_Q62 = 64'h3243F6A8885A308D;

    localparam logic signed [LAT_W-1:0]  CENTER_LAT_RST = 31'sd230149750;
    localparam logic signed [LON_W-1:0]  CENTER_LON_RST = 32'sd726395700;
    localparam logic        [DIST_W-1:0] RADIUS_RST     = 25'd1000;

    // atan(2^-i) in Q.w, built from the odd power series at elaboration
    function automatic logic [63:0] arc_entry(input int i, input int w);
        logic [63:0] q;
        logic [63:0] t;
        int          e;
        q = '0;
        if (i == 0) begin
            q = QUARTER_PI_Q62;
        end else begin
            for (int k = 0; k < 32; k++) begin
                e = 62 - i * (2 * k + 1);
                if (e >= 0) begin
                    t = (64'd1 << e) / 64'(2 * k + 1);
                    if ((k & 1) == 1) begin
                        q = q - t;
                    end else begin
                        q = q + t;
                    end
                end
            end
        end
        return (q + (64'd1 << (61 - w))) >> (62 - w);
    endfunction

endpackage

// ===== rtl/core/hgf_mulr.sv =====
// Two-stage unsigned multiplier from four partial products, rounded right shift.
`timescale 1ns / 1ps

module hgf_mulr #(
    parameter int A_W   = 41,
    parameter int B_W   = 41,
    parameter int SHIFT = 40,
    parameter int OUT_W = A_W + B_W - SHIFT
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [A_W-1:0]   i_a,
    input  logic [B_W-1:0]   i_b,
    output logic [OUT_W-1:0] o_p
);

    localparam int AL    = (A_W + 1) / 2;
    localparam int AH    = A_W - AL;
    localparam int BL    = (B_W + 1) / 2;
    localparam int BH    = B_W - BL;
    localparam int SUM_W = A_W + B_W;

    logic [AH+BH-1:0] r_hh;
    logic [AH+BL-1:0] r_hl;
    logic [AL+BH-1:0] r_lh;
    logic [AL+BL-1:0] r_ll;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= i_a[A_W-1:AL] * i_b[B_W-1:BL];
            r_hl <= (AH+BL)'(i_a[A_W-1:AL]) * (AH+BL)'(i_b[BL-1:0]);
            r_lh <= (AL+BH)'(i_a[AL-1:0]) * (AL+BH)'(i_b[B_W-1:BL]);
            r_ll <= (AL+BL)'(i_a[AL-1:0]) * (AL+BL)'(i_b[BL-1:0]);
        end
    end

    // sum partials, add half an LSB of the result
    assign n_sum = (SUM_W'(r_hh) << (AL + BL)) + (SUM_W'(r_hl) << AL)
                 + (SUM_W'(r_lh) << BL) + SUM_W'(r_ll)
                 + (SUM_W'(1) << (SHIFT - 1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_p = r_sum[SHIFT +: OUT_W];

endmodule

// ===== rtl/core/haversine_geofence_check.sv =====
// Top level of the haversine circular geofence check.
`timescale 1ns / 1ps

// Each input beat carries one position fix; each output beat carries the
// status (no fix, inside, outside) and the great-circle distance in whole
// metres from the configured centre on a sphere of radius 6371000 m. The
// datapath is a single pipeline that takes one fix every clock cycle while
// the output is not stalled and keeps no state between fixes. It is built
// from three CORDIC pipelines in series: a sine/cosine rotation (three
// lanes in parallel), a magnitude vectoring stage (two lanes) and an
// arctangent vectoring stage, each ANGLE_FRAC_BITS + 11 stages long, plus
// five stages of angle folding and radian scaling, one absolute-value stage,
// two split multipliers of two stages each and the output register. The
// whole pipeline holds while the output beat waits, so o_ready follows
// i_ready when a result is pending. Configuration writes are always taken
// (o_cfg_ready is high); write the registers only while no fix is in flight.
module haversine_geofence_check #(
    parameter int ANGLE_FRAC_BITS = hgf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // fix input
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_fix_valid,
    input  logic signed [hgf_pkg::LAT_W-1:0] i_latitude,
    input  logic signed [hgf_pkg::LON_W-1:0] i_longitude,
    // result output
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [hgf_pkg::STATUS_W-1:0]    o_status,
    output logic [hgf_pkg::DIST_W-1:0]      o_distance_meters,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hgf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hgf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int F   = ANGLE_FRAC_BITS;
    localparam int W   = F + hgf_pkg::GUARD_BITS;  // working fraction bits
    localparam int N   = W + 1;                    // CORDIC steps
    localparam int RW  = W + 3;                    // rotation width
    localparam int SW  = W + 1;                    // |sin|, |cos| width
    localparam int PW  = 2 * SW - W;               // rounded product width
    localparam int VW  = W + 6;                    // vectoring width
    localparam int ZW  = W + 3;                    // arctangent accumulator
    localparam int TW  = hgf_pkg::TURN_W;
    localparam int L   = 10 + 3 * N;               // stages before the output register
    localparam logic signed [RW-1:0] X_INIT = RW'(1) << W;

    // Configuration registers
    logic signed [hgf_pkg::LAT_W-1:0]  r_clat;
    logic signed [hgf_pkg::LON_W-1:0]  r_clon;
    logic        [hgf_pkg::DIST_W-1:0] r_radius;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clat   <= hgf_pkg::CENTER_LAT_RST;
            r_clon   <= hgf_pkg::CENTER_LON_RST;
            r_radius <= hgf_pkg::RADIUS_RST;
        end else if (i_cfg_valid) begin
            case (hgf_pkg::t_cfg_index'(i_cfg_index))
                hgf_pkg::CFG_CENTER_LAT: r_clat   <= signed'(i_cfg_data[hgf_pkg::LAT_W-1:0]);
                hgf_pkg::CFG_CENTER_LON: r_clon   <= signed'(i_cfg_data[hgf_pkg::LON_W-1:0]);
                hgf_pkg::CFG_RADIUS:     r_radius <= i_cfg_data[hgf_pkg::DIST_W-1:0];
                default: ;  // unused index: drop the beat
            endcase
        end
    end

    // Pipeline advance: every stage moves together unless the output is stalled
    logic advance;
    logic r_out_valid;
    logic [L-1:0] r_vld;
    logic [L-1:0] r_fix;

    assign advance = !r_out_valid || i_ready;
    assign o_ready = advance;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_vld       <= {r_vld[L-2:0], i_valid};
            r_out_valid <= r_vld[L-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_fix <= {r_fix[L-2:0], i_fix_valid};
        end
    end

    // Stage 0: half-angle differences and sum (lane 0 dlat, 1 lat sum, 2 dlon)
    logic signed [TW-1:0] r_d0 [3];

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_d0[0] <= TW'(i_latitude) - TW'(r_clat);
            r_d0[1] <= TW'(i_latitude) + TW'(r_clat);
            r_d0[2] <= TW'(i_longitude) - TW'(r_clon);
        end
    end

    // Stage 1: wrap into one turn and take the magnitude
    // Stage 2: fold into the first quadrant
    // Stage 3: scale to radians, Stage 4: round into the CORDIC angle
    logic [31:0]          r_d1 [3];
    logic [30:0]          r_d2 [3];
    logic [62:0]          r_p3 [3];
    logic signed [RW-1:0] r_z4 [3];

    for (genvar gl = 0; gl < 3; gl++) begin : g_pre
        logic signed [TW-1:0] wrapped;
        logic [63:0]          rounded;

        always_comb begin
            wrapped = r_d0[gl];
            if (r_d0[gl] > hgf_pkg::HALF_TURN) begin
                wrapped = r_d0[gl] - hgf_pkg::FULL_TURN;
            end else if (r_d0[gl] < -hgf_pkg::HALF_TURN) begin
                wrapped = r_d0[gl] + hgf_pkg::FULL_TURN;
            end
        end

        assign rounded = 64'(r_p3[gl]) + (64'd1 << (61 - F));

        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_d1[gl] <= wrapped[TW-1] ? 32'(-wrapped) : 32'(wrapped);
                r_d2[gl] <= (r_d1[gl] > hgf_pkg::QUARTER_TURN)
                          ? 31'(hgf_pkg::HALF_TURN_U - r_d1[gl]) : r_d1[gl][30:0];
                r_p3[gl] <= 63'(r_d2[gl]) * 63'(hgf_pkg::RAD_SCALE);
                r_z4[gl] <= signed'(RW'(rounded[62-F +: F+1]) << hgf_pkg::GUARD_BITS);
            end
        end
    end

    // Rotation CORDIC: |sin| and |cos| of each half angle, gain left in
    logic signed [RW-1:0] r_rx [N][3];
    logic signed [RW-1:0] r_ry [N][3];
    logic signed [RW-1:0] r_rz [N][3];

    for (genvar gi = 0; gi < N; gi++) begin : g_rot
        localparam logic signed [RW-1:0] ANG = RW'(hgf_pkg::arc_entry(gi, W));
        for (genvar gl = 0; gl < 3; gl++) begin : g_lane
            logic signed [RW-1:0] px;
            logic signed [RW-1:0] py;
            logic signed [RW-1:0] pz;
            if (gi == 0) begin : g_first
                assign px = X_INIT;
                assign py = '0;
                assign pz = r_z4[gl];
            end else begin : g_next
                assign px = r_rx[gi-1][gl];
                assign py = r_ry[gi-1][gl];
                assign pz = r_rz[gi-1][gl];
            end
            always_ff @(posedge i_clk) begin
                if (advance) begin
                    if (!pz[RW-1]) begin
                        r_rx[gi][gl] <= px - (py >>> gi);
                        r_ry[gi][gl] <= py + (px >>> gi);
                        r_rz[gi][gl] <= pz - ANG;
                    end else begin
                        r_rx[gi][gl] <= px + (py >>> gi);
                        r_ry[gi][gl] <= py - (px >>> gi);
                        r_rz[gi][gl] <= pz + ANG;
                    end
                end
            end
        end
    end

    // Magnitudes of the rotation results
    logic [SW-1:0] r_sin [3];
    logic [SW-1:0] r_cos [3];

    for (genvar gl = 0; gl < 3; gl++) begin : g_abs
        logic signed [RW-1:0] xs;
        logic signed [RW-1:0] ys;
        assign xs = r_rx[N-1][gl];
        assign ys = r_ry[N-1][gl];
        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_sin[gl] <= ys[RW-1] ? SW'(-ys) : SW'(ys);
                r_cos[gl] <= xs[RW-1] ? SW'(-xs) : SW'(xs);
            end
        end
    end

    // Sum-of-squares terms: a from (sd*cl, cs*sl), 1-a from (cd*cl, ss*sl)
    logic [PW-1:0] prod [4];

    hgf_mulr #(.A_W(SW), .B_W(SW), .SHIFT(W), .OUT_W(PW)) u_mul_sdcl (
        .i_clk(i_clk), .i_en(advance), .i_a(r_sin[0]), .i_b(r_cos[2]), .o_p(prod[0])
    );
    hgf_mulr #(.A_W(SW), .B_W(SW), .SHIFT(W), .OUT_W(PW)) u_mul_cssl (
        .i_clk(i_clk), .i_en(advance), .i_a(r_cos[1]), .i_b(r_sin[2]), .o_p(prod[1])
    );
    hgf_mulr #(.A_W(SW), .B_W(SW), .SHIFT(W), .OUT_W(PW)) u_mul_cdcl (
        .i_clk(i_clk), .i_en(advance), .i_a(r_cos[0]), .i_b(r_cos[2]), .o_p(prod[2])
    );
    hgf_mulr #(.A_W(SW), .B_W(SW), .SHIFT(W), .OUT_W(PW)) u_mul_sssl (
        .i_clk(i_clk), .i_en(advance), .i_a(r_sin[1]), .i_b(r_sin[2]), .o_p(prod[3])
    );

    // Vectoring CORDIC: lane 0 gives gain*sqrt(a), lane 1 gain*sqrt(1-a)
    logic signed [VW-1:0] r_vx [N][2];
    logic signed [VW-1:0] r_vy [N][2];

    for (genvar gi = 0; gi < N; gi++) begin : g_mag
        for (genvar gl = 0; gl < 2; gl++) begin : g_lane
            logic signed [VW-1:0] px;
            logic signed [VW-1:0] py;
            if (gi == 0) begin : g_first
                assign px = signed'(VW'(prod[2*gl]));
                assign py = signed'(VW'(prod[2*gl+1]));
            end else begin : g_next
                assign px = r_vx[gi-1][gl];
                assign py = r_vy[gi-1][gl];
            end
            always_ff @(posedge i_clk) begin
                if (advance) begin
                    if (py > 0) begin
                        r_vx[gi][gl] <= px + (py >>> gi);
                        r_vy[gi][gl] <= py - (px >>> gi);
                    end else begin
                        r_vx[gi][gl] <= px - (py >>> gi);
                        r_vy[gi][gl] <= py + (px >>> gi);
                    end
                end
            end
        end
    end

    // Arctangent CORDIC: c/2 = atan2(sqrt(a), sqrt(1-a)); the gains cancel
    logic signed [VW-1:0] r_ax [N];
    logic signed [VW-1:0] r_ay [N];
    logic signed [ZW-1:0] r_az [N];

    for (genvar gi = 0; gi < N; gi++) begin : g_atn
        localparam logic signed [ZW-1:0] ANG = ZW'(hgf_pkg::arc_entry(gi, W));
        logic signed [VW-1:0] px;
        logic signed [VW-1:0] py;
        logic signed [ZW-1:0] pz;
        if (gi == 0) begin : g_first
            assign px = r_vx[N-1][1];
            assign py = r_vx[N-1][0];
            assign pz = '0;
        end else begin : g_next
            assign px = r_ax[gi-1];
            assign py = r_ay[gi-1];
            assign pz = r_az[gi-1];
        end
        always_ff @(posedge i_clk) begin
            if (advance) begin
                if (py > 0) begin
                    r_ax[gi] <= px + (py >>> gi);
                    r_ay[gi] <= py - (px >>> gi);
                    r_az[gi] <= pz + ANG;
                end else begin
                    r_ax[gi] <= px - (py >>> gi);
                    r_ay[gi] <= py + (px >>> gi);
                    r_az[gi] <= pz - ANG;
                end
            end
        end
    end

    // Distance: round(12742000 * c/2), negative angle clamped to zero
    logic [W:0]                   half_arc;
    logic [hgf_pkg::DIST_W-1:0]   dist_m;

    assign half_arc = r_az[N-1][ZW-1] ? '0 : r_az[N-1][W:0];

    hgf_mulr #(
        .A_W(hgf_pkg::TWO_RADII_W), .B_W(W + 1), .SHIFT(W), .OUT_W(hgf_pkg::DIST_W)
    ) u_mul_dist (
        .i_clk(i_clk), .i_en(advance), .i_a(hgf_pkg::TWO_RADII_M), .i_b(half_arc),
        .o_p(dist_m)
    );

    // Output register: hold while the beat waits
    hgf_pkg::t_status           r_status;
    hgf_pkg::t_status           n_status;
    logic [hgf_pkg::DIST_W-1:0] r_dist;
    logic [hgf_pkg::DIST_W-1:0] n_dist;

    always_comb begin
        if (!r_fix[L-1]) begin
            n_status = hgf_pkg::ST_NO_FIX;
            n_dist   = '0;
        end else begin
            n_status = (dist_m > r_radius) ? hgf_pkg::ST_OUTSIDE : hgf_pkg::ST_INSIDE;
            n_dist   = dist_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_status <= n_status;
            r_dist   <= n_dist;
        end
    end

    assign o_status          = r_status;
    assign o_distance_meters = r_dist;

endmodule

// ===== rtl/core/hgf_checker.sv =====
// Port-level assertions for the haversine geofence check, bound to the top level.
`timescale 1ns / 1ps

module hgf_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            i_fix_valid,
    input logic signed [hgf_pkg::LAT_W-1:0] i_latitude,
    input logic signed [hgf_pkg::LON_W-1:0] i_longitude,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [hgf_pkg::STATUS_W-1:0]    o_status,
    input logic [hgf_pkg::DIST_W-1:0]      o_distance_meters,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [hgf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [hgf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_distance_meters))
        else $error("result beat changed while stalled");

    // no fix means zero distance
    a_no_fix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == hgf_pkg::ST_NO_FIX) |-> (o_distance_meters == '0))
        else $error("no-fix result with nonzero distance");

    // pipeline takes a fix whenever no result waits
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input held off with empty output");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_valid)
        else $error("result beat straight after reset");

endmodule

bind haversine_geofence_check hgf_checker u_hgf_checker (.*);
